FILE: hdl/vfc_pkg.sv
// Package for the VGA frame capture block: field widths, register indexes
// and timing error codes. It has no dependencies.
package vfc_pkg;

  // Configuration port.
  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 12;

  localparam logic [CfgIdxW-1:0] REG_LINE_LENGTH     = 3'd0;
  localparam logic [CfgIdxW-1:0] REG_FRAME_LINES     = 3'd1;
  localparam logic [CfgIdxW-1:0] REG_VISIBLE_X_FIRST = 3'd2;
  localparam logic [CfgIdxW-1:0] REG_VISIBLE_X_LAST  = 3'd3;
  localparam logic [CfgIdxW-1:0] REG_VISIBLE_Y_FIRST = 3'd4;
  localparam logic [CfgIdxW-1:0] REG_VISIBLE_Y_LAST  = 3'd5;

  // Register widths.
  localparam int unsigned LenW    = 12;
  localparam int unsigned BoundW  = 11;
  localparam int unsigned MeasW   = 11;
  localparam int unsigned ColourW = 8;

  // Reset values of the timing registers.
  localparam logic [LenW-1:0]   LINE_LENGTH_RST     = 12'd800;
  localparam logic [LenW-1:0]   FRAME_LINES_RST     = 12'd525;
  localparam logic [BoundW-1:0] VISIBLE_X_FIRST_RST = 11'd0;
  localparam logic [BoundW-1:0] VISIBLE_X_LAST_RST  = 11'd639;
  localparam logic [BoundW-1:0] VISIBLE_Y_FIRST_RST = 11'd0;
  localparam logic [BoundW-1:0] VISIBLE_Y_LAST_RST  = 11'd479;

  // Input sample: hsync, vsync, red, green, blue from bit 0 up.
  localparam int unsigned InBits  = 10;
  localparam int unsigned InDataW = 16;

  // Output flags in tuser.
  localparam int unsigned OutUserW = 8;

  typedef enum logic [1:0] {
    ERR_NONE  = 2'd0,
    ERR_LINE  = 2'd1,
    ERR_FRAME = 2'd2
  } timing_err_e;

endpackage

FILE: hdl/vga_frame_capture.sv
// VGA frame capture: sync tracking, timing checks and frame buffer writes.
// Depends on vfc_pkg for widths, register indexes and error codes.
//
// Usage: one video sample (sync levels and a 3-3-2 colour) is offered per
// pixel clock on the slave stream. For every accepted sample exactly one
// result leaves on the master stream: a frame buffer write (address and
// colour) when the sample lies in the visible window, a frame done flag on
// a correctly timed vertical sync, a timing error with the measured column or
// line count, or an empty result otherwise. Results come out in input order.
// The input register feeds the sync state machine and counter stage, whose
// register feeds the address multiply-add that loads the output register.
// Throughput is one sample per cycle while the receiver does not stall.
// When the receiver stalls, the three stages fill and the slave side keeps
// taking samples until all of them hold data, then tready drops. No result
// is dropped. Reset empties the pipeline, returns the state machine to the
// video area with zeroed counters and loads the default 640x480 timing.
// The user writes the timing registers through the plain write port only while no
// sample is in flight; the block itself does not enforce this.
module vga_frame_capture #(
  parameter int unsigned COORD_BITS = 11,
  parameter int unsigned ADDR_BITS  = 19,
  localparam int unsigned OutDataBits = ADDR_BITS + vfc_pkg::ColourW + vfc_pkg::MeasW,
  localparam int unsigned OutDataW    = ((OutDataBits + 7) / 8) * 8
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // Configuration writes.
  input  logic                          cfg_we_i,
  input  logic [vfc_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  logic [vfc_pkg::CfgDataW-1:0]  cfg_data_i,
  // Video samples.
  input  logic                          s_axis_tvalid_i,
  output logic                          s_axis_tready_o,
  // tdata: hsync_level, vsync_level, red_level[2:0], green_level[2:0], blue_level[1:0]
  input  logic [vfc_pkg::InDataW-1:0]   s_axis_tdata_i,
  // Results.
  output logic                          m_axis_tvalid_o,
  input  logic                          m_axis_tready_i,
  // tdata: pixel_address, pixel_colour[7:0], measured_count[10:0]
  output logic [OutDataW-1:0]           m_axis_tdata_o,
  // tuser: pixel_write, frame_done, timing_error[1:0]
  output logic [vfc_pkg::OutUserW-1:0]  m_axis_tuser_o
);

  localparam int unsigned CmpW  = (COORD_BITS > vfc_pkg::LenW) ? COORD_BITS : vfc_pkg::LenW;
  localparam int unsigned ProdW = CmpW + vfc_pkg::LenW;
  localparam int unsigned SumW  = (ProdW + 1 > ADDR_BITS) ? ProdW + 1 : ADDR_BITS;

  typedef enum logic [2:0] {
    ST_VIDEO    = 3'd0,
    ST_HPULSE   = 3'd1,
    ST_VPULSE   = 3'd2,
    ST_LOST     = 3'd3,
    ST_LOST_EOF = 3'd4
  } cap_state_e;

  // Timing registers.
  logic [vfc_pkg::LenW-1:0]   line_length_q, frame_lines_q;
  logic [vfc_pkg::BoundW-1:0] x_first_q, x_last_q, y_first_q, y_last_q;

  // Pipeline occupancy and flow control.
  logic a_valid_q, b_valid_q, c_valid_q;
  logic a_ready, b_ready, c_ready;
  logic a_move, b_move;

  // Input register.
  logic [vfc_pkg::InBits-1:0] a_data_q;

  // State machine and counters.
  cap_state_e            state_q, state_d;
  logic [COORD_BITS-1:0] col_q, col_d, line_q, line_d;

  // Stage B registers.
  logic                        b_wr_q, b_wr_d;
  logic [CmpW-1:0]             b_dx_q, b_dx_d, b_dy_q, b_dy_d;
  logic [vfc_pkg::LenW-1:0]    b_width_q, b_width_d;
  logic [vfc_pkg::ColourW-1:0] b_colour_q, b_colour_d;
  logic                        b_done_q, b_done_d;
  vfc_pkg::timing_err_e        b_err_q, b_err_d;
  logic [vfc_pkg::MeasW-1:0]   b_meas_q, b_meas_d;

  // Output register.
  logic                        c_wr_q;
  logic [ADDR_BITS-1:0]        c_addr_q, c_addr_d;
  logic [vfc_pkg::ColourW-1:0] c_colour_q;
  logic                        c_done_q;
  vfc_pkg::timing_err_e        c_err_q;
  logic [vfc_pkg::MeasW-1:0]   c_meas_q;

  // Combinational helpers for stage A.
  logic                        hs, vs;
  logic [vfc_pkg::ColourW-1:0] colour;
  logic [CmpW-1:0]             col_ext, line_ext;
  logic [vfc_pkg::LenW-1:0]    exp_cols, exp_lines;
  logic                        visible;
  logic [COORD_BITS-1:0]       col_inc, line_inc;

  // Stage B multiply-add.
  logic [ProdW-1:0] prod;
  logic [SumW-1:0]  sum;

  assign c_ready = !c_valid_q || m_axis_tready_i;
  assign b_ready = !b_valid_q || c_ready;
  assign a_ready = !a_valid_q || b_ready;
  assign a_move  = a_valid_q && b_ready;
  assign b_move  = b_valid_q && c_ready;

  assign s_axis_tready_o = a_ready;

  assign hs     = a_data_q[0];
  assign vs     = a_data_q[1];
  assign colour = {a_data_q[4:2], a_data_q[7:5], a_data_q[9:8]};

  assign col_ext   = CmpW'(col_q);
  assign line_ext  = CmpW'(line_q);
  // A zero length wraps to 4095, which the counters never match.
  assign exp_cols  = line_length_q - vfc_pkg::LenW'(1);
  assign exp_lines = frame_lines_q - vfc_pkg::LenW'(1);

  assign visible = (col_ext >= CmpW'(x_first_q)) && (col_ext <= CmpW'(x_last_q)) &&
                   (line_ext >= CmpW'(y_first_q)) && (line_ext <= CmpW'(y_last_q));

  // Counters saturate at all ones.
  assign col_inc  = (&col_q) ? col_q : col_q + COORD_BITS'(1);
  assign line_inc = (&line_q) ? line_q : line_q + COORD_BITS'(1);

  always_comb begin
    state_d    = state_q;
    col_d      = col_q;
    line_d     = line_q;
    b_wr_d     = 1'b0;
    b_done_d   = 1'b0;
    b_err_d    = vfc_pkg::ERR_NONE;
    b_meas_d   = '0;
    b_dx_d     = col_ext - CmpW'(x_first_q);
    b_dy_d     = line_ext - CmpW'(y_first_q);
    b_width_d  = {1'b0, x_last_q} - {1'b0, x_first_q} + vfc_pkg::LenW'(1);
    b_colour_d = '0;
    unique case (state_q)
      ST_VIDEO: begin
        if (!vs) begin
          if (line_ext != CmpW'(exp_lines)) begin
            b_err_d  = vfc_pkg::ERR_FRAME;
            b_meas_d = line_ext[vfc_pkg::MeasW-1:0];
            state_d  = ST_LOST_EOF;
          end else begin
            col_d    = '0;
            line_d   = '0;
            b_done_d = 1'b1;
            state_d  = ST_VPULSE;
          end
        end else if (!hs) begin
          if (col_ext != CmpW'(exp_cols)) begin
            b_err_d  = vfc_pkg::ERR_LINE;
            b_meas_d = col_ext[vfc_pkg::MeasW-1:0];
            state_d  = ST_LOST_EOF;
          end else begin
            col_d   = '0;
            line_d  = line_inc;
            state_d = ST_HPULSE;
          end
        end else begin
          if (visible) begin
            b_wr_d     = 1'b1;
            b_colour_d = colour;
          end
          col_d = col_inc;
        end
      end
      ST_HPULSE: begin
        if (hs) begin
          state_d = ST_VIDEO;
        end
      end
      ST_VPULSE: begin
        if (vs) begin
          state_d = ST_VIDEO;
        end
      end
      ST_LOST_EOF: begin
        if (vs) begin
          state_d = ST_LOST;
        end
      end
      default: begin
        // Sync lost, and any code outside the state list, waits for vsync.
        if (!vs) begin
          col_d   = '0;
          line_d  = '0;
          state_d = ST_VPULSE;
        end
      end
    endcase
  end

  // The offset only matters when the pixel is written, so the window width
  // is positive whenever it is used.
  assign prod     = ProdW'(b_dy_q) * ProdW'(b_width_q);
  assign sum      = SumW'(prod) + SumW'(b_dx_q);
  assign c_addr_d = b_wr_q ? sum[ADDR_BITS-1:0] : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      line_length_q <= vfc_pkg::LINE_LENGTH_RST;
      frame_lines_q <= vfc_pkg::FRAME_LINES_RST;
      x_first_q     <= vfc_pkg::VISIBLE_X_FIRST_RST;
      x_last_q      <= vfc_pkg::VISIBLE_X_LAST_RST;
      y_first_q     <= vfc_pkg::VISIBLE_Y_FIRST_RST;
      y_last_q      <= vfc_pkg::VISIBLE_Y_LAST_RST;
      a_valid_q     <= 1'b0;
      b_valid_q     <= 1'b0;
      c_valid_q     <= 1'b0;
      state_q       <= ST_VIDEO;
      col_q         <= '0;
      line_q        <= '0;
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          vfc_pkg::REG_LINE_LENGTH:     line_length_q <= cfg_data_i;
          vfc_pkg::REG_FRAME_LINES:     frame_lines_q <= cfg_data_i;
          vfc_pkg::REG_VISIBLE_X_FIRST: x_first_q <= cfg_data_i[vfc_pkg::BoundW-1:0];
          vfc_pkg::REG_VISIBLE_X_LAST:  x_last_q  <= cfg_data_i[vfc_pkg::BoundW-1:0];
          vfc_pkg::REG_VISIBLE_Y_FIRST: y_first_q <= cfg_data_i[vfc_pkg::BoundW-1:0];
          vfc_pkg::REG_VISIBLE_Y_LAST:  y_last_q  <= cfg_data_i[vfc_pkg::BoundW-1:0];
          default: begin
          end
        endcase
      end
      if (a_ready) begin
        a_valid_q <= s_axis_tvalid_i;
      end
      if (b_ready) begin
        b_valid_q <= a_valid_q;
      end
      if (c_ready) begin
        c_valid_q <= b_valid_q;
      end
      if (a_move) begin
        state_q <= state_d;
        col_q   <= col_d;
        line_q  <= line_d;
      end
    end
  end

  // Payload registers, no reset needed.
  always_ff @(posedge clk_i) begin
    if (a_ready && s_axis_tvalid_i) begin
      a_data_q <= s_axis_tdata_i[vfc_pkg::InBits-1:0];
    end
    if (a_move) begin
      b_wr_q     <= b_wr_d;
      b_dx_q     <= b_dx_d;
      b_dy_q     <= b_dy_d;
      b_width_q  <= b_width_d;
      b_colour_q <= b_colour_d;
      b_done_q   <= b_done_d;
      b_err_q    <= b_err_d;
      b_meas_q   <= b_meas_d;
    end
    if (b_move) begin
      c_wr_q     <= b_wr_q;
      c_addr_q   <= c_addr_d;
      c_colour_q <= b_colour_q;
      c_done_q   <= b_done_q;
      c_err_q    <= b_err_q;
      c_meas_q   <= b_meas_q;
    end
  end

  assign m_axis_tvalid_o = c_valid_q;
  assign m_axis_tdata_o  = OutDataW'({c_meas_q, c_colour_q, c_addr_q});
  assign m_axis_tuser_o  = vfc_pkg::OutUserW'({c_err_q, c_done_q, c_wr_q});

endmodule

FILE: sim/vga_frame_capture_test.sv
// Self-checking testbench for vga_frame_capture: a directed table, then random
// video timing with idling on both streams and a full-size window sweep, checked against a sync tracker.
// Depends on vfc_pkg and the vga_frame_capture RTL.
module vga_frame_capture_test;

  localparam int unsigned ResDataW      = 40;
  localparam int unsigned HoldOffCycles = 64;
  localparam int unsigned DrainLimit    = 5000;
  localparam int unsigned DrainCycles   = 6;
  localparam int unsigned PhaseSamples  = 150;
  localparam int unsigned SweepLines    = 20;
  localparam int unsigned SweepPixels   = 20;
  localparam int unsigned MaxPrinted    = 50;
  localparam int DirRows = 33;
  localparam int TxIdlePct  [4] = '{0, 54, 0, 19};
  localparam int RxStallPct [4] = '{0, 0, 54, 19};

  typedef enum logic [2:0] {
    CS_VIDEO,
    CS_HPULSE,
    CS_VPULSE,
    CS_LOST,
    CS_LOST_EOF
  } cap_state_e;

  typedef enum logic {ROW_SAMPLE, ROW_REG} row_kind_e;

  // hsync sits in bit 0, blue in the top bits.
  typedef struct packed {
    logic [1:0] blue;
    logic [2:0] green;
    logic [2:0] red;
    logic       vsync;
    logic       hsync;
  } sample_t;

  typedef struct packed {
    logic                        wr;
    logic [18:0]                 addr;
    logic [vfc_pkg::ColourW-1:0] colour;
    logic                        done;
    vfc_pkg::timing_err_e        err;
    logic [vfc_pkg::MeasW-1:0]   meas;
  } result_t;

  typedef struct packed {
    row_kind_e                    kind;
    logic [vfc_pkg::CfgIdxW-1:0]  idx;
    logic [vfc_pkg::CfgDataW-1:0] val;
    sample_t                      smp;
    logic                         typed;
    result_t                      res;
  } dir_row_t;

  logic                         clk_i;
  logic                         rst_ni;
  logic                         cfg_we_i;
  logic [vfc_pkg::CfgIdxW-1:0]  cfg_idx_i;
  logic [vfc_pkg::CfgDataW-1:0] cfg_data_i;
  logic                         s_axis_tvalid_i;
  logic                         s_axis_tready_o;
  logic [vfc_pkg::InDataW-1:0]  s_axis_tdata_i;
  logic                         m_axis_tvalid_o;
  logic                         m_axis_tready_i;
  logic [ResDataW-1:0]          m_axis_tdata_o;
  logic [vfc_pkg::OutUserW-1:0] m_axis_tuser_o;

  // Sync tracker state and its copy of the timing registers.
  cap_state_e                 cap_state;
  logic [10:0]                col_cnt;
  logic [10:0]                line_cnt;
  logic [vfc_pkg::LenW-1:0]   exp_line_len;
  logic [vfc_pkg::LenW-1:0]   exp_frame_lines;
  logic [vfc_pkg::BoundW-1:0] win_x_first;
  logic [vfc_pkg::BoundW-1:0] win_x_last;
  logic [vfc_pkg::BoundW-1:0] win_y_first;
  logic [vfc_pkg::BoundW-1:0] win_y_last;

  result_t  sample_outcomes[$];
  dir_row_t dir_table[DirRows];
  int       samples_sent;
  int       mismatches;
  int       tx_idle_pct;
  int       rx_stall_pct;
  int       hold_off_reqs;

  vga_frame_capture u_top (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_idx_i       (cfg_idx_i),
    .cfg_data_i      (cfg_data_i),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tuser_o  (m_axis_tuser_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  task automatic report_mismatch(string what, logic [31:0] want, logic [31:0] got);
    if (mismatches < MaxPrinted) begin
      $display("%0t: %s: expected %0d, got %0d", $realtime, what, want, got);
    end
    mismatches++;
  endtask

  function automatic logic rbit();
    return 1'($urandom_range(1));
  endfunction

  function automatic logic [10:0] sat_next(logic [10:0] v);
    return (v == '1) ? v : v + 11'd1;
  endfunction

  function automatic sample_t rand_sample(logic hs, logic vs);
    sample_t s;
    s.hsync = hs;
    s.vsync = vs;
    s.red   = 3'($urandom_range(7));
    s.green = 3'($urandom_range(7));
    s.blue  = 2'($urandom_range(3));
    return s;
  endfunction

  // Advances the sync tracker by one sample and returns the result it causes.
  function automatic result_t track_sample(sample_t s);
    result_t     r;
    logic [31:0] offs;
    r = '0;
    offs = '0;
    case (cap_state)
      CS_VIDEO: begin
        if (!s.vsync) begin
          if ({1'b0, line_cnt} != exp_frame_lines - 12'd1) begin
            r.err = vfc_pkg::ERR_FRAME;
            r.meas = line_cnt;
            cap_state = CS_LOST_EOF;
          end else begin
            col_cnt = '0;
            line_cnt = '0;
            r.done = 1'b1;
            cap_state = CS_VPULSE;
          end
        end else if (!s.hsync) begin
          if ({1'b0, col_cnt} != exp_line_len - 12'd1) begin
            r.err = vfc_pkg::ERR_LINE;
            r.meas = col_cnt;
            cap_state = CS_LOST_EOF;
          end else begin
            col_cnt = '0;
            line_cnt = sat_next(line_cnt);
            cap_state = CS_HPULSE;
          end
        end else begin
          if (col_cnt >= win_x_first && col_cnt <= win_x_last &&
              line_cnt >= win_y_first && line_cnt <= win_y_last) begin
            offs = (32'(col_cnt) - 32'(win_x_first)) +
                   (32'(line_cnt) - 32'(win_y_first)) *
                   (32'(win_x_last) - 32'(win_x_first) + 32'd1);
            r.wr = 1'b1;
            r.addr = offs[18:0];
            r.colour = {s.red, s.green, s.blue};
          end
          col_cnt = sat_next(col_cnt);
        end
      end
      CS_HPULSE: if (s.hsync) cap_state = CS_VIDEO;
      CS_VPULSE: if (s.vsync) cap_state = CS_VIDEO;
      CS_LOST_EOF: if (s.vsync) cap_state = CS_LOST;
      default: begin
        if (!s.vsync) begin
          col_cnt = '0;
          line_cnt = '0;
          cap_state = CS_VPULSE;
        end
      end
    endcase
    return r;
  endfunction

  function automatic result_t mk_result(logic wr, logic [18:0] addr, logic [7:0] colour,
                                        logic done, vfc_pkg::timing_err_e err,
                                        logic [10:0] meas);
    result_t r;
    r.wr = wr;
    r.addr = addr;
    r.colour = colour;
    r.done = done;
    r.err = err;
    r.meas = meas;
    return r;
  endfunction

  function automatic dir_row_t reg_row(logic [vfc_pkg::CfgIdxW-1:0] idx,
                                       logic [vfc_pkg::CfgDataW-1:0] val);
    dir_row_t d;
    d = '0;
    d.kind = ROW_REG;
    d.idx = idx;
    d.val = val;
    return d;
  endfunction

  function automatic dir_row_t smp_row(logic hs, logic vs, logic [2:0] red,
                                       logic [2:0] green, logic [1:0] blue);
    dir_row_t d;
    d = '0;
    d.kind = ROW_SAMPLE;
    d.smp.hsync = hs;
    d.smp.vsync = vs;
    d.smp.red = red;
    d.smp.green = green;
    d.smp.blue = blue;
    return d;
  endfunction

  function automatic dir_row_t chk_row(logic hs, logic vs, logic [2:0] red, logic [2:0] green,
                                       logic [1:0] blue, result_t res);
    dir_row_t d;
    d = smp_row(hs, vs, red, green, blue);
    d.typed = 1'b1;
    d.res = res;
    return d;
  endfunction

  // Lowers valid, waits until every result has come back, then lets the pipe settle.
  task automatic wait_idle();
    int guard;
    guard = 0;
    s_axis_tvalid_i <= 1'b0;
    while (sample_outcomes.size() != 0 && guard < DrainLimit) begin
      @(posedge clk_i);
      guard++;
    end
    if (sample_outcomes.size() != 0) begin
      report_mismatch("results never delivered", 0, sample_outcomes.size());
      sample_outcomes.delete();
    end
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [vfc_pkg::CfgIdxW-1:0] idx, logic [vfc_pkg::CfgDataW-1:0] val);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
    case (idx)
      vfc_pkg::REG_LINE_LENGTH:     exp_line_len = val;
      vfc_pkg::REG_FRAME_LINES:     exp_frame_lines = val;
      vfc_pkg::REG_VISIBLE_X_FIRST: win_x_first = val[vfc_pkg::BoundW-1:0];
      vfc_pkg::REG_VISIBLE_X_LAST:  win_x_last = val[vfc_pkg::BoundW-1:0];
      vfc_pkg::REG_VISIBLE_Y_FIRST: win_y_first = val[vfc_pkg::BoundW-1:0];
      vfc_pkg::REG_VISIBLE_Y_LAST:  win_y_last = val[vfc_pkg::BoundW-1:0];
      default: ;
    endcase
  endtask

  task automatic apply_timing(int unsigned len, int unsigned lines, int unsigned xf,
                              int unsigned xl, int unsigned yf, int unsigned yl);
    wait_idle();
    write_reg(vfc_pkg::REG_LINE_LENGTH, 12'(len));
    write_reg(vfc_pkg::REG_FRAME_LINES, 12'(lines));
    write_reg(vfc_pkg::REG_VISIBLE_X_FIRST, 12'(xf));
    write_reg(vfc_pkg::REG_VISIBLE_X_LAST, 12'(xl));
    write_reg(vfc_pkg::REG_VISIBLE_Y_FIRST, 12'(yf));
    write_reg(vfc_pkg::REG_VISIBLE_Y_LAST, 12'(yl));
  endtask

  // Records the expected outcome and offers the sample until the transfer happens.
  task automatic push_sample(sample_t s, logic typed, result_t fixed);
    result_t r;
    r = track_sample(s);
    sample_outcomes.insert(sample_outcomes.size(), typed ? fixed : r);
    samples_sent++;
    while ($urandom_range(99) < tx_idle_pct) begin
      s_axis_tvalid_i <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tdata_i <= vfc_pkg::InDataW'(s);
    @(posedge clk_i);
    while (!s_axis_tready_o) @(posedge clk_i);
  endtask

  // One frame at the current timing, with an occasional wrong line width or noise sample.
  task automatic send_frame();
    int len;
    int lines;
    int npx;
    len = int'(exp_line_len);
    lines = int'(exp_frame_lines);
    for (int ln = 0; ln < lines - 1; ln++) begin
      npx = len - 1;
      if ($urandom_range(99) < 4) npx = len - 2 + int'($urandom_range(2));
      if (npx < 0) npx = 0;
      repeat (npx) push_sample(rand_sample(1'b1, 1'b1), 1'b0, '0);
      push_sample(rand_sample(1'b0, 1'b1), 1'b0, '0);
      repeat ($urandom_range(2)) push_sample(rand_sample(1'b0, rbit()), 1'b0, '0);
      push_sample(rand_sample(1'b1, rbit()), 1'b0, '0);
      if ($urandom_range(99) < 3) push_sample(rand_sample(rbit(), rbit()), 1'b0, '0);
    end
    repeat ($urandom_range(len)) push_sample(rand_sample(1'b1, 1'b1), 1'b0, '0);
    push_sample(rand_sample(rbit(), 1'b0), 1'b0, '0);
    repeat ($urandom_range(2)) push_sample(rand_sample(rbit(), 1'b0), 1'b0, '0);
    push_sample(rand_sample(rbit(), 1'b1), 1'b0, '0);
  endtask

  // Receiver: random stalls, or a long hold-off on request.
  initial begin
    int served;
    served = 0;
    m_axis_tready_i <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_off_reqs != served) begin
        served = hold_off_reqs;
        m_axis_tready_i <= 1'b0;
        for (int n = 0; n < HoldOffCycles; n++) @(posedge clk_i);
      end else begin
        m_axis_tready_i <= ($urandom_range(99) >= rx_stall_pct);
      end
    end
  end

  always @(posedge clk_i) begin : result_check
    result_t got;
    result_t want;
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i) begin
      got.addr   = m_axis_tdata_o[18:0];
      got.colour = m_axis_tdata_o[26:19];
      got.meas   = m_axis_tdata_o[37:27];
      got.wr     = m_axis_tuser_o[0];
      got.done   = m_axis_tuser_o[1];
      got.err    = vfc_pkg::timing_err_e'(m_axis_tuser_o[3:2]);
      if (sample_outcomes.size() == 0) begin
        report_mismatch("result with nothing pending", 0, 1);
      end else begin
        want = sample_outcomes[0];
        sample_outcomes.delete(0);
        if (got.wr !== want.wr)
          report_mismatch("pixel_write", 32'(want.wr), 32'(got.wr));
        if (got.addr !== want.addr)
          report_mismatch("pixel_address", 32'(want.addr), 32'(got.addr));
        if (got.colour !== want.colour)
          report_mismatch("pixel_colour", 32'(want.colour), 32'(got.colour));
        if (got.done !== want.done)
          report_mismatch("frame_done", 32'(want.done), 32'(got.done));
        if (got.err !== want.err)
          report_mismatch("timing_error", 32'(want.err), 32'(got.err));
        if (got.meas !== want.meas)
          report_mismatch("measured_count", 32'(want.meas), 32'(got.meas));
      end
    end
  end

  initial begin
    #(2_000_000);
    $display("Simulation FAILED");
    $finish;
  end

  initial begin
    int phase_end;
    rst_ni <= 1'b0;
    cfg_we_i <= 1'b0;
    cfg_idx_i <= '0;
    cfg_data_i <= '0;
    s_axis_tvalid_i <= 1'b0;
    s_axis_tdata_i <= '0;
    hold_off_reqs = 0;
    tx_idle_pct = 0;
    rx_stall_pct = 0;
    samples_sent = 0;
    mismatches = 0;
    cap_state = CS_VIDEO;
    col_cnt = '0;
    line_cnt = '0;
    exp_line_len = vfc_pkg::LINE_LENGTH_RST;
    exp_frame_lines = vfc_pkg::FRAME_LINES_RST;
    win_x_first = vfc_pkg::VISIBLE_X_FIRST_RST;
    win_x_last = vfc_pkg::VISIBLE_X_LAST_RST;
    win_y_first = vfc_pkg::VISIBLE_Y_FIRST_RST;
    win_y_last = vfc_pkg::VISIBLE_Y_LAST_RST;

    // Reset timing first, then a tiny 3x2 raster, then zero lengths that never match.
    dir_table = '{
      chk_row(1'b1, 1'b1, 3'd7, 3'd7, 2'd3,
              mk_result(1'b1, 19'd0, 8'hFF, 1'b0, vfc_pkg::ERR_NONE, 11'd0)),
      chk_row(1'b1, 1'b1, 3'd0, 3'd0, 2'd0,
              mk_result(1'b1, 19'd1, 8'h00, 1'b0, vfc_pkg::ERR_NONE, 11'd0)),
      chk_row(1'b0, 1'b1, 3'd5, 3'd2, 2'd1,
              mk_result(1'b0, 19'd0, 8'h00, 1'b0, vfc_pkg::ERR_LINE, 11'd2)),
      chk_row(1'b1, 1'b0, 3'd3, 3'd3, 2'd2,
              mk_result(1'b0, 19'd0, 8'h00, 1'b0, vfc_pkg::ERR_NONE, 11'd0)),
      smp_row(1'b1, 1'b1, 3'd1, 3'd6, 2'd0),
      smp_row(1'b0, 1'b0, 3'd2, 3'd5, 2'd3),
      smp_row(1'b0, 1'b1, 3'd4, 3'd1, 2'd2),
      chk_row(1'b1, 1'b0, 3'd6, 3'd4, 2'd1,
              mk_result(1'b0, 19'd0, 8'h00, 1'b0, vfc_pkg::ERR_FRAME, 11'd0)),
      reg_row(vfc_pkg::REG_LINE_LENGTH, 12'd3),
      reg_row(vfc_pkg::REG_FRAME_LINES, 12'd2),
      reg_row(vfc_pkg::REG_VISIBLE_X_FIRST, 12'd1),
      reg_row(vfc_pkg::REG_VISIBLE_X_LAST, 12'd2),
      reg_row(vfc_pkg::REG_VISIBLE_Y_FIRST, 12'd0),
      reg_row(vfc_pkg::REG_VISIBLE_Y_LAST, 12'd1),
      smp_row(1'b1, 1'b1, 3'd7, 3'd0, 2'd1),
      smp_row(1'b1, 1'b0, 3'd0, 3'd7, 2'd2),
      smp_row(1'b1, 1'b1, 3'd3, 3'd2, 2'd1),
      smp_row(1'b1, 1'b1, 3'd5, 3'd5, 2'd0),
      smp_row(1'b1, 1'b1, 3'd2, 3'd6, 2'd3),
      smp_row(1'b0, 1'b1, 3'd1, 3'd1, 2'd1),
      smp_row(1'b0, 1'b0, 3'd6, 3'd3, 2'd2),
      smp_row(1'b1, 1'b0, 3'd4, 3'd4, 2'd0),
      smp_row(1'b1, 1'b1, 3'd0, 3'd2, 2'd3),
      smp_row(1'b1, 1'b1, 3'd7, 3'd5, 2'd2),
      chk_row(1'b1, 1'b0, 3'd3, 3'd6, 2'd1,
              mk_result(1'b0, 19'd0, 8'h00, 1'b1, vfc_pkg::ERR_NONE, 11'd0)),
      smp_row(1'b0, 1'b1, 3'd2, 3'd0, 2'd3),
      reg_row(vfc_pkg::REG_LINE_LENGTH, 12'd0),
      reg_row(vfc_pkg::REG_FRAME_LINES, 12'd0),
      chk_row(1'b0, 1'b1, 3'd1, 3'd7, 2'd0,
              mk_result(1'b0, 19'd0, 8'h00, 1'b0, vfc_pkg::ERR_LINE, 11'd0)),
      smp_row(1'b1, 1'b1, 3'd6, 3'd6, 2'd1),
      smp_row(1'b0, 1'b0, 3'd5, 3'd1, 2'd2),
      smp_row(1'b1, 1'b1, 3'd4, 3'd3, 2'd3),
      chk_row(1'b1, 1'b0, 3'd0, 3'd4, 2'd0,
              mk_result(1'b0, 19'd0, 8'h00, 1'b0, vfc_pkg::ERR_FRAME, 11'd0))
    };

    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    foreach (dir_table[i]) begin
      if (dir_table[i].kind == ROW_REG) begin
        wait_idle();
        write_reg(dir_table[i].idx, dir_table[i].val);
      end else begin
        push_sample(dir_table[i].smp, dir_table[i].typed, dir_table[i].res);
      end
    end

    // Random frames with small timings; the first phase also holds the receiver off.
    for (int ph = 0; ph < 4; ph++) begin
      wait_idle();
      tx_idle_pct = TxIdlePct[ph];
      rx_stall_pct = RxStallPct[ph];
      phase_end = samples_sent + PhaseSamples;
      while (samples_sent < phase_end) begin
        apply_timing($urandom_range(1, 9), $urandom_range(1, 5), $urandom_range(3),
                     $urandom_range(8), $urandom_range(2), $urandom_range(4));
        if (ph == 0 && samples_sent < phase_end - PhaseSamples + 10) hold_off_reqs++;
        repeat ($urandom_range(2, 4)) send_frame();
      end
    end

    // Sweep a full-size window from the origin, then close on the widest timing.
    tx_idle_pct = 0;
    rx_stall_pct = 0;
    apply_timing(1, 0, 0, 2047, 0, 2047);
    while (cap_state != CS_VIDEO || col_cnt != 0 || line_cnt != 0) begin
      push_sample(rand_sample(1'b1, (cap_state == CS_VIDEO || cap_state == CS_LOST) ? 1'b0 : 1'b1),
                  1'b0, '0);
    end
    repeat (SweepLines) begin
      push_sample(rand_sample(1'b0, 1'b1), 1'b0, '0);
      push_sample(rand_sample(1'b1, rbit()), 1'b0, '0);
    end
    repeat (SweepPixels) push_sample(rand_sample(1'b1, 1'b1), 1'b0, '0);
    wait_idle();
    write_reg(vfc_pkg::REG_LINE_LENGTH, 12'd2048);
    push_sample(rand_sample(1'b0, 1'b1), 1'b0, '0);
    push_sample(rand_sample(1'b1, 1'b1), 1'b0, '0);
    wait_idle();
    write_reg(vfc_pkg::REG_FRAME_LINES, 12'd2048);
    push_sample(rand_sample(rbit(), 1'b0), 1'b0, '0);
    push_sample(rand_sample(rbit(), 1'b1), 1'b0, '0);

    wait_idle();
    if (mismatches == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
